// File: design/luhn_pkg.sv
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared widths, result codes and digit helpers for the Luhn card classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int CARD_W      = 63;                 // binary card number width
    localparam int BCD_DIGITS  = 19;                 // enough for 2^63 - 1
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int LUHN_DIGITS = 16;                 // digits that enter the total
    localparam int LUHN_W      = 4 * LUHN_DIGITS;
    localparam int CONV_CNT_W  = $clog2(CARD_W);
    localparam int POS_W       = $clog2(LUHN_DIGITS);

    typedef logic [3:0] digit_t;
    typedef logic [4:0] count_t;

    localparam count_t COUNT_TOO_LONG = count_t'(LUHN_DIGITS + 1);

    // card_class codes
    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_15_3X   = 2'd1;
    localparam logic [1:0] CLS_16_5X   = 2'd2;
    localparam logic [1:0] CLS_LEAD_4  = 2'd3;

    // Luhn pass result handed to the top level
    typedef struct packed {
        logic   ok;       // digit total is a multiple of ten
        count_t count;    // 1..16, position of highest non-zero digit
    } luhn_res_t;

    // Double a digit and fold a two-digit product to its digit sum
    function automatic digit_t luhn_double(input digit_t d);
        logic [4:0] twice;
        twice = {d, 1'b0};
        if (d >= 4'd5)
            luhn_double = digit_t'(twice - 5'd9);
        else
            luhn_double = digit_t'(twice);
    endfunction

endpackage

// File: design/luhn_card_number_classifier_core.sv
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_core
// Luhn mod-10 check and card classification of a binary card number.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | beat
//  --------+--------------------------------------------+---------------------
//  in      | in_valid, in_stall, card_number[62:0]      | one number to check
//  out     | out_valid, out_stall, card_class[1:0],     | one classification
//          | checksum_ok, digit_count[4:0]              |
//
//  Steps: shift-and-add-3 BCD conversion of the 63 input bits, one bit at a
//  time, then Luhn accumulation over the low 16 digits, one digit at a time,
//  a handover between them and a load of the output register. A new beat is
//  taken only after the previous result has left the sequencer, so beats
//  do not overlap inside the converter or the accumulator.
//  The next beat is taken once the result sits in the output register, so a
//  waiting result does not hold up the next conversion.
//  Reset (rst_n, async, active low) empties the pipeline and the output.
//  out_stall holds the output register; a finished result waits in HOLD.
//
module luhn_card_number_classifier_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [luhn_pkg::CARD_W-1:0] card_number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  card_class,
    output logic                        checksum_ok,
    output luhn_pkg::count_t            digit_count
);
    import luhn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LUHN,
        ST_HOLD
    } state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    logic [1:0] class_reg;
    logic       ok_reg;
    count_t     count_reg;

    logic            in_take;
    logic            out_take;
    logic            conv_done;
    logic [BCD_W-1:0] bcd;
    logic            luhn_done;
    luhn_res_t       luhn_res;

    logic            too_long;
    count_t          count_fin;
    logic [1:0]      class_fin;
    logic            out_free;
    logic            finish;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    luhn_bcd_conv u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_take),
        .number (card_number),
        .done   (conv_done),
        .bcd    (bcd)
    );

    luhn_digit_acc u_acc
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_done),
        .digits (bcd[LUHN_W-1:0]),
        .done   (luhn_done),
        .res    (luhn_res)
    );

    // Classification. The BCD word stays put until the next beat starts.
    always_comb
    begin
        too_long  = |bcd[BCD_W-1:LUHN_W];
        count_fin = too_long ? COUNT_TOO_LONG : luhn_res.count;
        class_fin = CLS_INVALID;
        if (luhn_res.ok && !too_long)
        begin
            case (luhn_res.count)
                count_t'(15):
                begin
                    // prefix 34 or 37
                    if (bcd[4*14 +: 4] == 4'd3 &&
                        (bcd[4*13 +: 4] == 4'd4 || bcd[4*13 +: 4] == 4'd7))
                        class_fin = CLS_15_3X;
                end
                count_t'(16):
                begin
                    // prefix 51..55 wins; otherwise leading 4
                    if (bcd[4*15 +: 4] == 4'd5 &&
                        bcd[4*14 +: 4] >= 4'd1 && bcd[4*14 +: 4] <= 4'd5)
                        class_fin = CLS_16_5X;
                    else if (bcd[4*15 +: 4] == 4'd4)
                        class_fin = CLS_LEAD_4;
                end
                count_t'(13):
                begin
                    if (bcd[4*12 +: 4] == 4'd4)
                        class_fin = CLS_LEAD_4;
                end
                default:
                begin
                    class_fin = CLS_INVALID;
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = ((state_reg == ST_LUHN && luhn_done) || state_reg == ST_HOLD)
                      && out_free;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            class_reg     <= CLS_INVALID;
            ok_reg        <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_take)
                out_valid_reg <= 1'b0;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                class_reg     <= class_fin;
                ok_reg        <= luhn_res.ok;
                count_reg     <= count_fin;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                        state_reg <= ST_CONV;
                end
                ST_CONV:
                begin
                    if (conv_done)
                        state_reg <= ST_LUHN;
                end
                ST_LUHN:
                begin
                    if (luhn_done)
                        state_reg <= finish ? ST_IDLE : ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (finish)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign card_class  = class_reg;
    assign checksum_ok = ok_reg;
    assign digit_count = count_reg;

    // converter finishes only while the sequencer waits for it
    a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> state_reg == ST_CONV)
        else $error("BCD conversion finished outside CONV");

    a_luhn_done_in_luhn: assert property (@(posedge clk) disable iff (!rst_n)
        luhn_done |-> state_reg == ST_LUHN)
        else $error("Luhn pass finished outside LUHN");

    a_take_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == ST_CONV)
        else $error("accepted beat did not start conversion");

    a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && class_reg != CLS_INVALID |-> ok_reg &&
        (count_reg == count_t'(13) || count_reg == count_t'(15) ||
         count_reg == count_t'(16)))
        else $error("card class given without checksum or valid length");

endmodule

// File: design/luhn_bcd_conv.sv
// ----------------------------------------------------------------------------
// luhn_bcd_conv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module luhn_bcd_conv
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [luhn_pkg::CARD_W-1:0] number,
    output logic                        done,
    output logic [luhn_pkg::BCD_W-1:0]  bcd
);
    import luhn_pkg::*;

    logic [CARD_W-1:0]     bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CONV_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CONV_CNT_W'(1);
                if (cnt_reg == CONV_CNT_W'(CARD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[CARD_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[CARD_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: design/luhn_digit_acc.sv
// ----------------------------------------------------------------------------
// luhn_digit_acc
// Digit-serial Luhn total (mod 10) and digit count over the low 16 digits.
// ----------------------------------------------------------------------------
module luhn_digit_acc
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [luhn_pkg::LUHN_W-1:0] digits,
    output logic                        done,
    output luhn_pkg::luhn_res_t         res
);
    import luhn_pkg::*;

    logic [LUHN_W-1:0] sr_reg;
    logic [POS_W-1:0]  pos_reg;
    digit_t            total_reg;
    count_t            count_reg;
    logic              busy_reg;
    logic              done_reg;

    digit_t     cur;
    digit_t     term;
    logic [4:0] sum;
    digit_t     total_next;

    always_comb
    begin
        cur  = sr_reg[3:0];
        // odd positions from zero are the second, fourth, ... digits
        term = pos_reg[0] ? luhn_double(cur) : cur;
        sum  = {1'b0, total_reg} + {1'b0, term};
        if (sum >= 5'd10)
            total_next = digit_t'(sum - 5'd10);
        else
            total_next = digit_t'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            pos_reg   <= '0;
            total_reg <= '0;
            count_reg <= count_t'(1);
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                pos_reg   <= '0;
                total_reg <= '0;
                count_reg <= count_t'(1);
            end
            else if (busy_reg)
            begin
                pos_reg   <= pos_reg + POS_W'(1);
                total_reg <= total_next;
                if (cur != 4'd0)
                    count_reg <= count_t'({1'b0, pos_reg}) + count_t'(1);
                if (pos_reg == POS_W'(LUHN_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            sr_reg <= digits;
        else if (busy_reg)
            sr_reg <= {4'd0, sr_reg[LUHN_W-1:4]};
    end

    assign done     = done_reg;
    assign res.ok   = (total_reg == 4'd0);
    assign res.count = count_reg;

endmodule
